// File: design/wic_pkg.sv
// Package for the wiper interval and wash controller.
// Holds payload structs, code constants, reset values and the delay table.
// No dependencies; imported by wic_level, wiper_interval_wash_controller and tb_top.
package wic_pkg;

  localparam int DUTY_W  = 11;
  localparam int TICK_W  = 32;
  localparam int CFG_W   = 40;
  localparam int CFG_IDX_W = 3;

  localparam int WIC_FULL_DUTY_DEF = 1250;

  // Width of duty * 255, and of the reciprocal used to divide it by the full duty.
  localparam int LVL_X_W = DUTY_W + 8;
  localparam int LVL_M_W = LVL_X_W + 2;

  typedef struct packed {
    logic [7:0]  vehicle_speed;
    logic [2:0]  stalk_mode;
    logic [11:0] rain_level;
    logic        timer_fault;
  } wic_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] wiper_duty;
    logic [1:0]        wipe_phase;
    logic [7:0]        wiper_level;
    logic              washing_active;
  } wic_out_t;

  // Result of the state update, before the level scaling.
  typedef struct packed {
    logic [DUTY_W-1:0] wiper_duty;
    logic [1:0]        wipe_phase;
    logic              washing_active;
  } wic_mid_t;

  typedef enum logic [1:0] {
    PH_PARKED = 2'd0,
    PH_OUT    = 2'd1,
    PH_BACK   = 2'd2
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOW_STEP      = 3'd0,
    REG_FAST_STEP      = 3'd1,
    REG_WASH_WINDOW    = 3'd2,
    REG_WASH_WIPES     = 3'd3,
    REG_SPEED_LIMITS   = 3'd4,
    REG_RAIN_THRESHOLD = 3'd5
  } cfg_reg_t;

  localparam logic [2:0] MODE_OFF      = 3'd0;
  localparam logic [2:0] MODE_AUTO     = 3'd1;
  localparam logic [2:0] MODE_INT_SLOW = 3'd2;
  localparam logic [2:0] MODE_INT_FAST = 3'd3;
  localparam logic [2:0] MODE_WASH     = 3'd4;

  localparam logic [2:0] BAND_NONE = 3'd0;
  localparam logic [2:0] BAND_TOP  = 3'd6;

  localparam logic [39:0] SPEED_LIMITS_RST   = 40'h32_281E_0F05;
  localparam logic [11:0] RAIN_THRESHOLD_RST = 12'd3000;

  // Intermittent delays in ticks, by mode (slow, fast) and by speed band.
  localparam logic [10:0] DELAY_TABLE [2][6] = '{
    '{11'd1400, 11'd1300, 11'd1200, 11'd1100, 11'd1000, 11'd800},
    '{11'd700,  11'd600,  11'd500,  11'd400,  11'd300,  11'd200}
  };

endpackage

// File: design/wic_level.sv
// Output stage of the wiper controller: scales the duty to a 0..255 level
// and holds the result transaction. Depends on wic_pkg.
module wic_level #(
  parameter int FULL_DUTY = wic_pkg::WIC_FULL_DUTY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              mid_valid,
  output logic              mid_ready,
  input  wic_pkg::wic_mid_t mid_data,
  output logic              out_valid,
  input  logic              out_ready,
  output wic_pkg::wic_out_t out_data
);
  import wic_pkg::*;

  // floor(x / FULL_DUTY) == (x * LvlMul) >> LvlShift for every x below 2**LVL_X_W.
  localparam int LvlShift = LVL_X_W + $clog2(FULL_DUTY);
  localparam longint unsigned LvlMulFull =
    ((64'd1 << LvlShift) + 64'(FULL_DUTY) - 64'd1) / 64'(FULL_DUTY);
  localparam logic [LVL_M_W-1:0] LvlMul = LvlMulFull[LVL_M_W-1:0];

  logic [LVL_X_W-1:0]         scaled;
  logic [LVL_X_W+LVL_M_W-1:0] product;
  logic [7:0]                 level;

  assign scaled  = {mid_data.wiper_duty, 8'd0} - LVL_X_W'(mid_data.wiper_duty);
  assign product = LVL_X_W'(0) + scaled * LvlMul;
  assign level   = product[LvlShift +: 8];

  assign mid_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mid_ready) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_ready && mid_valid) begin
      out_data.wiper_duty     <= mid_data.wiper_duty;
      out_data.wipe_phase     <= mid_data.wipe_phase;
      out_data.wiper_level    <= level;
      out_data.washing_active <= mid_data.washing_active;
    end
  end

endmodule

// File: design/wiper_interval_wash_controller.sv
// Top level of the wiper interval and wash controller.
// Holds the input stage, configuration registers and the per-tick state update.
// Depends on wic_pkg and instantiates wic_level.

// Each accepted input transaction is one control tick and yields exactly one result
// transaction. The block is a three-register pipeline: an input register, the
// tick state update (speed band, sweep ramp, auto, intermittent and wash
// decisions) registered in a middle stage, and an output stage that adds the
// 0..255 level, computed as duty * 255 / FULL_DUTY with a constant reciprocal
// multiply. A result passes through the input, middle and output registers in
// order, and a new input transaction can be accepted in every cycle while the
// output side does not stall; the state update, which every tick passes through
// in order, sets the throughput. Each stage has its own valid bit, but the input
// and middle stages move on only when the output stage has room.
// Configuration registers are written through cfg_write, cfg_index and
// cfg_data and take effect on the next tick; they should only be written while
// no transaction is in flight. Indexes beyond the register list are ignored.
module wiper_interval_wash_controller #(
  parameter int FULL_DUTY = wic_pkg::WIC_FULL_DUTY_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  wic_pkg::wic_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output wic_pkg::wic_out_t               out_data,
  input  logic                            cfg_write,
  input  logic [wic_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wic_pkg::CFG_W-1:0]       cfg_data
);
  import wic_pkg::*;

  // Configuration registers.
  logic [7:0]  slow_step;
  logic [7:0]  fast_step;
  logic [7:0]  wash_window;
  logic [7:0]  wash_wipes;
  logic [39:0] speed_limits;
  logic [11:0] rain_threshold;

  // Pipeline stages.
  logic     s1_valid;
  logic     s1_ready;
  wic_in_t  s1_data;
  logic     s2_valid;
  logic     s2_ready;
  wic_mid_t s2_data;
  logic     s1_fire;

  // Tick state.
  logic [TICK_W-1:0] tick_count,     tick_count_next;
  phase_t            sweep_phase,    sweep_phase_next;
  logic [DUTY_W-1:0] duty_value,     duty_value_next;
  logic [2:0]        speed_band,     speed_band_next;
  logic [TICK_W-1:0] interval_start, interval_start_next;
  phase_t            seen_phase,     seen_phase_next;
  logic [7:0]        wash_remaining, wash_remaining_next;
  logic [TICK_W-1:0] wash_start,     wash_start_next;

  // Combinational helpers for the update.
  logic [7:0]        limit [5];
  logic [6:1]        band_hit;
  logic [2:0]        band_cls;
  logic [7:0]        step;
  logic [DUTY_W:0]   duty_sum;
  logic [2:0]        delay_band;
  logic [10:0]       delay;
  logic [TICK_W-1:0] interval_age;
  logic [TICK_W-1:0] wash_age;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      slow_step      <= 8'd0;
      fast_step      <= 8'd0;
      wash_window    <= 8'd0;
      wash_wipes     <= 8'd0;
      speed_limits   <= SPEED_LIMITS_RST;
      rain_threshold <= RAIN_THRESHOLD_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_SLOW_STEP:      slow_step      <= cfg_data[7:0];
        REG_FAST_STEP:      fast_step      <= cfg_data[7:0];
        REG_WASH_WINDOW:    wash_window    <= cfg_data[7:0];
        REG_WASH_WIPES:     wash_wipes     <= cfg_data[7:0];
        REG_SPEED_LIMITS:   speed_limits   <= cfg_data[39:0];
        REG_RAIN_THRESHOLD: rain_threshold <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input and middle stages move on only when the output stage has room.
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;
  assign s1_fire  = s1_valid && s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_data <= in_data;
    end
    if (s1_fire) begin
      s2_data.wiper_duty     <= duty_value_next;
      s2_data.wipe_phase     <= sweep_phase_next;
      s2_data.washing_active <= (wash_remaining_next != 8'd0);
    end
  end

  // Speed band: the first matching band wins; with no match the band is kept.
  always_comb begin
    for (int k = 0; k < 5; k++) begin
      limit[k] = speed_limits[8*k +: 8];
    end
    band_hit[1] = s1_data.vehicle_speed <= limit[0];
    for (int k = 2; k <= 5; k++) begin
      band_hit[k] = (s1_data.vehicle_speed > limit[k-2]) &&
                    (s1_data.vehicle_speed <= limit[k-1]);
    end
    band_hit[6] = s1_data.vehicle_speed > limit[4];
    band_cls = speed_band;
    for (int k = 6; k >= 1; k--) begin
      if (band_hit[k]) begin
        band_cls = 3'(k);
      end
    end
  end

  assign step       = (band_cls == BAND_TOP) ? fast_step : slow_step;
  assign duty_sum   = {1'b0, duty_value} + (DUTY_W+1)'(step);
  assign delay_band = (band_cls == BAND_NONE) ? 3'd0 : band_cls - 3'd1;
  assign delay      = DELAY_TABLE[s1_data.stalk_mode[0]][delay_band];

  // Tick state update.
  always_comb begin
    tick_count_next     = tick_count + TICK_W'(1);
    sweep_phase_next    = sweep_phase;
    duty_value_next     = duty_value;
    speed_band_next     = speed_band;
    interval_start_next = interval_start;
    seen_phase_next     = seen_phase;
    wash_remaining_next = wash_remaining;
    wash_start_next     = wash_start;
    interval_age        = '0;
    wash_age            = '0;

    if (!s1_data.timer_fault) begin
      speed_band_next = band_cls;

      // Ramp out until the next step would reach full duty, then back to park.
      case (sweep_phase)
        PH_OUT: begin
          if (duty_sum < (DUTY_W+1)'(FULL_DUTY)) begin
            duty_value_next = duty_sum[DUTY_W-1:0];
          end else begin
            sweep_phase_next = PH_BACK;
          end
        end
        PH_BACK: begin
          if (duty_value > DUTY_W'(step)) begin
            duty_value_next = duty_value - DUTY_W'(step);
          end else begin
            sweep_phase_next = PH_PARKED;
            duty_value_next  = '0;
          end
        end
        default: ;
      endcase

      if (s1_data.stalk_mode == MODE_AUTO &&
          s1_data.rain_level >= rain_threshold) begin
        if (sweep_phase_next == PH_PARKED) begin
          sweep_phase_next = PH_OUT;
        end
      end else if (s1_data.stalk_mode == MODE_INT_SLOW ||
                   s1_data.stalk_mode == MODE_INT_FAST) begin
        // The interval restarts whenever the sweep phase changes.
        if (seen_phase != sweep_phase_next) begin
          seen_phase_next     = sweep_phase_next;
          interval_start_next = '0;
        end
        if (interval_start_next == '0) begin
          interval_start_next = tick_count;
        end
        interval_age = tick_count - interval_start_next;
        if (interval_age >= TICK_W'(delay)) begin
          sweep_phase_next = PH_OUT;
        end
      end else if (s1_data.stalk_mode == MODE_WASH) begin
        if (wash_start == '0) begin
          wash_start_next     = tick_count;
          wash_remaining_next = wash_wipes;
        end
      end else begin
        interval_start_next = '0;
        seen_phase_next     = PH_PARKED;
      end

      // Inside the wash window a parked wiper is always started.
      wash_age = tick_count - wash_start_next;
      if (wash_start_next != '0 && wash_age < TICK_W'(wash_window)) begin
        if (sweep_phase_next == PH_PARKED) begin
          sweep_phase_next = PH_OUT;
          if (wash_remaining_next != 8'd0) begin
            wash_remaining_next = wash_remaining_next - 8'd1;
          end
        end
      end
      if (sweep_phase_next == PH_PARKED && wash_remaining_next != 8'd0) begin
        sweep_phase_next    = PH_OUT;
        wash_remaining_next = wash_remaining_next - 8'd1;
      end
      if (wash_remaining_next == 8'd0) begin
        wash_start_next = '0;
      end
    end else begin
      // A timer fault drops the sweep but keeps the wash sequence.
      duty_value_next     = '0;
      interval_start_next = '0;
      sweep_phase_next    = PH_PARKED;
      seen_phase_next     = PH_PARKED;
      speed_band_next     = BAND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      sweep_phase    <= PH_PARKED;
      duty_value     <= '0;
      speed_band     <= BAND_NONE;
      interval_start <= '0;
      seen_phase     <= PH_PARKED;
      wash_remaining <= '0;
      wash_start     <= '0;
    end else if (s1_fire) begin
      tick_count     <= tick_count_next;
      sweep_phase    <= sweep_phase_next;
      duty_value     <= duty_value_next;
      speed_band     <= speed_band_next;
      interval_start <= interval_start_next;
      seen_phase     <= seen_phase_next;
      wash_remaining <= wash_remaining_next;
      wash_start     <= wash_start_next;
    end
  end

  wic_level #(
    .FULL_DUTY(FULL_DUTY)
  ) u_level (
    .clk      (clk),
    .rst      (rst),
    .mid_valid(s2_valid),
    .mid_ready(s2_ready),
    .mid_data (s2_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for wiper_interval_wash_controller.
// Predicts every result from its own model of the control tick and checks it field by field.
// Depends on wic_pkg and on the controller RTL.
`timescale 1ns / 100ps

module tb_top;
  import wic_pkg::*;

  // The controller is built with its default full PWM period. The testbench keeps
  // its own copy of the constants so that the RTL package values are checked too.
  localparam int unsigned FULL_DUTY_TICKS = 1250;
  localparam logic [39:0] DEFAULT_SPEED_LIMITS = 40'h32_281E_0F05; // 5, 15, 30, 40, 50
  localparam logic [11:0] DEFAULT_RAIN_THRESHOLD = 12'd3000;

  // Stalk positions beyond wash behave like off.
  localparam logic [2:0] MODE_SPARE5 = 3'd5;
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  wic_in_t in_data;
  logic out_valid;
  logic out_ready;
  wic_out_t out_data;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  wiper_interval_wash_controller dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the configuration registers, starting from their reset values.
  logic [7:0] slow_step_cfg = 8'd0;
  logic [7:0] fast_step_cfg = 8'd0;
  logic [7:0] wash_window_cfg = 8'd0;
  logic [7:0] wash_wipes_cfg = 8'd0;
  logic [39:0] speed_limits_cfg = DEFAULT_SPEED_LIMITS;
  logic [11:0] rain_threshold_cfg = DEFAULT_RAIN_THRESHOLD;

  // Model of the controller state. A timestamp of zero means "not set".
  logic [31:0] wiper_tick = '0;
  phase_t wiper_phase = PH_PARKED;
  logic [10:0] wiper_duty_now = '0;
  logic [2:0] wiper_band = BAND_NONE;
  logic [31:0] wiper_interval_from = '0;
  phase_t wiper_seen_phase = PH_PARKED;
  logic [7:0] wash_left = '0;
  logic [31:0] wash_from = '0;

  // Results the controller still owes us, oldest first.
  wic_out_t expected_wiper_q[$];
  int mismatch_count = 0;

  // Idling controls shared between the stimulus and the result sink.
  bit sender_steady = 1'b0;
  bit receiver_steady = 1'b0;
  int rx_hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap lengths are mostly short, with the occasional long one.
  function automatic int gap_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int sender_gap();
    if (sender_steady || $urandom_range(0, 99) < 60) return 0;
    return gap_length();
  endfunction

  // Intermittent wait in ticks. Band 0 (not yet classified) takes the band 1 delay.
  function automatic int unsigned interval_delay(input bit fast, input logic [2:0] band);
    int unsigned b;
    b = (band >= 3'd1 && band <= 3'd6) ? band - 1 : 0;
    case (b)
      0: return fast ? 700 : 1400;
      1: return fast ? 600 : 1300;
      2: return fast ? 500 : 1200;
      3: return fast ? 400 : 1100;
      4: return fast ? 300 : 1000;
      default: return fast ? 200 : 800;
    endcase
  endfunction

  // One control tick of the model. Updates the state and returns the result.
  function automatic wic_out_t advance_wiper(input wic_in_t t);
    wic_out_t r;
    int unsigned step;
    int unsigned duty;
    bit found;
    if (!t.timer_fault) begin
      // Speed bands are tested in order; with odd limits the band may stay as it was.
      found = 1'b0;
      if (t.vehicle_speed <= speed_limits_cfg[7:0]) begin
        wiper_band = 3'd1;
        found = 1'b1;
      end
      for (int k = 1; k < 5; k++) begin
        if (!found && t.vehicle_speed > speed_limits_cfg[8*(k-1) +: 8] &&
            t.vehicle_speed <= speed_limits_cfg[8*k +: 8]) begin
          wiper_band = 3'(k + 1);
          found = 1'b1;
        end
      end
      if (!found && t.vehicle_speed > speed_limits_cfg[39:32]) wiper_band = BAND_TOP;

      // Ramp the duty. A step that would reach the full period turns the sweep back
      // without moving, and a step at least as large as the duty parks it.
      step = (wiper_band == BAND_TOP) ? fast_step_cfg : slow_step_cfg;
      duty = wiper_duty_now;
      if (wiper_phase == PH_OUT) begin
        if (duty + step < FULL_DUTY_TICKS) duty += step;
        else wiper_phase = PH_BACK;
      end else if (wiper_phase == PH_BACK) begin
        if (duty > step) begin
          duty -= step;
        end else begin
          wiper_phase = PH_PARKED;
          duty = 0;
        end
      end
      wiper_duty_now = 11'(duty);

      if (t.stalk_mode == MODE_AUTO && t.rain_level >= rain_threshold_cfg) begin
        if (wiper_phase == PH_PARKED) wiper_phase = PH_OUT;
      end else if (t.stalk_mode == MODE_INT_SLOW || t.stalk_mode == MODE_INT_FAST) begin
        // Every change of sweep phase restarts the interval.
        if (wiper_seen_phase != wiper_phase) begin
          wiper_seen_phase = wiper_phase;
          wiper_interval_from = '0;
        end
        if (wiper_interval_from == '0) wiper_interval_from = wiper_tick;
        if (wiper_tick - wiper_interval_from >=
            interval_delay(t.stalk_mode == MODE_INT_FAST, wiper_band))
          wiper_phase = PH_OUT;
      end else if (t.stalk_mode == MODE_WASH) begin
        if (wash_from == '0) begin
          wash_from = wiper_tick;
          wash_left = wash_wipes_cfg;
        end
      end else begin
        wiper_interval_from = '0;
        wiper_seen_phase = PH_PARKED;
      end

      // Forced wipes inside the wash window, then the remaining wash count.
      // The count saturates at zero.
      if (wash_from != '0 && (wiper_tick - wash_from) < wash_window_cfg) begin
        if (wiper_phase == PH_PARKED) begin
          wiper_phase = PH_OUT;
          if (wash_left > 0) wash_left--;
        end
      end
      if (wiper_phase == PH_PARKED && wash_left > 0) begin
        wiper_phase = PH_OUT;
        wash_left--;
      end
      if (wash_left == 0) wash_from = '0;
    end else begin
      // A timer fault drops the sweep but keeps the wash sequence.
      wiper_duty_now = '0;
      wiper_interval_from = '0;
      wiper_phase = PH_PARKED;
      wiper_seen_phase = PH_PARKED;
      wiper_band = BAND_NONE;
    end

    r.wiper_duty = wiper_duty_now;
    r.wipe_phase = wiper_phase;
    r.wiper_level = 8'((int'(wiper_duty_now) * 255) / FULL_DUTY_TICKS);
    r.washing_active = (wash_left != 0);
    wiper_tick++;
    return r;
  endfunction

  function automatic wic_in_t tick_of(input logic [7:0] spd, input logic [2:0] mode,
                                      input logic [11:0] rain, input logic fault);
    wic_in_t t;
    t.vehicle_speed = spd;
    t.stalk_mode = mode;
    t.rain_level = rain;
    t.timer_fault = fault;
    return t;
  endfunction

  // A quarter of the rain readings sit within one of the auto threshold.
  function automatic logic [11:0] pick_rain();
    if ($urandom_range(0, 3) == 0)
      return 12'(int'(rain_threshold_cfg) + int'($urandom_range(0, 2)) - 1);
    return 12'($urandom_range(0, 4095));
  endfunction

  function automatic wic_in_t make_tick(input logic [2:0] mode, input int spd_lo,
                                        input int spd_hi, input int fault_pct);
    return tick_of(8'($urandom_range(spd_lo, spd_hi)), mode, pick_rain(),
                   $urandom_range(0, 99) < fault_pct);
  endfunction

  // Offers one tick after a random gap and records the expected result once the
  // transaction is accepted. Valid stays high after acceptance; the next call
  // either drops it or replaces the payload at the following falling edge.
  task automatic send_tick(input wic_in_t t);
    int gap;
    gap = sender_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= t;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_wiper_q.push_back(advance_wiper(t));
  endtask

  task automatic send_run(input logic [2:0] mode, input int count, input int spd_lo,
                          input int spd_hi, input int fault_pct);
    repeat (count) send_tick(make_tick(mode, spd_lo, spd_hi, fault_pct));
  endtask

  // Runs of one stalk position at a time, mostly the given one.
  task automatic send_runs(input int total, input logic [2:0] main_mode,
                           input int fault_pct);
    int sent;
    int len;
    logic [2:0] mode;
    sent = 0;
    while (sent < total) begin
      mode = ($urandom_range(0, 99) < 60) ? main_mode : 3'($urandom_range(0, 7));
      len = $urandom_range(2, 12);
      send_run(mode, len, 0, 255, fault_pct);
      sent += len;
    end
  endtask

  // Stops offering input and waits until every result has come back, so that the
  // block is idle for a register write.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_wiper_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [39:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_SLOW_STEP: slow_step_cfg = val[7:0];
      REG_FAST_STEP: fast_step_cfg = val[7:0];
      REG_WASH_WINDOW: wash_window_cfg = val[7:0];
      REG_WASH_WIPES: wash_wipes_cfg = val[7:0];
      REG_SPEED_LIMITS: speed_limits_cfg = val;
      REG_RAIN_THRESHOLD: rain_threshold_cfg = val[11:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Result checker: every accepted result transaction is matched against the
  // oldest expectation.
  always @(posedge clk) begin : result_check
    wic_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_wiper_q.size() == 0) begin
        $display("%0t: unexpected result, actual duty %0d phase %0d level %0d washing %0d",
                 $time, out_data.wiper_duty, out_data.wipe_phase, out_data.wiper_level,
                 out_data.washing_active);
        mismatch_count++;
      end else begin
        want = expected_wiper_q.pop_front();
        check_field("wiper_duty", want.wiper_duty, out_data.wiper_duty);
        check_field("wipe_phase", want.wipe_phase, out_data.wipe_phase);
        check_field("wiper_level", want.wiper_level, out_data.wiper_level);
        check_field("washing_active", want.washing_active, out_data.washing_active);
      end
    end
  end

  // Result sink. Random short and long stalls, none while steady, and a long
  // hold-off counted here when a test asks for one.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        stall_left = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!receiver_steady && $urandom_range(0, 99) < 25) begin
        out_ready <= 1'b0;
        stall_left = gap_length() - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Reset values of the registers, with a wash requested on the very first tick
  // (a timestamp taken at tick zero reads as unset), band edges, every stalk
  // position and a timer fault.
  task automatic test_reset_values();
    write_reg(REG_SLOW_STEP, 40'd100);
    write_reg(REG_WASH_WIPES, 40'd2);
    send_tick(tick_of(8'd0, MODE_WASH, 12'd0, 1'b0));
    send_tick(tick_of(8'd255, MODE_OFF, 12'd4095, 1'b0));
    send_tick(tick_of(8'd5, MODE_AUTO, 12'd2999, 1'b0));
    send_tick(tick_of(8'd6, MODE_AUTO, 12'd3000, 1'b0));
    send_tick(tick_of(8'd15, MODE_SPARE5, 12'd4095, 1'b0));
    send_tick(tick_of(8'd16, MODE_SPARE6, 12'd0, 1'b0));
    send_tick(tick_of(8'd50, MODE_SPARE7, 12'd1, 1'b0));
    send_tick(tick_of(8'd51, MODE_INT_SLOW, 12'd2048, 1'b0));
    send_tick(tick_of(8'd30, MODE_INT_FAST, 12'd1024, 1'b0));
    send_tick(tick_of(8'd31, MODE_AUTO, 12'd4095, 1'b1));
    send_tick(tick_of(8'd40, MODE_AUTO, 12'd3000, 1'b0));
    send_tick(tick_of(8'd41, MODE_WASH, 12'd0, 1'b0));
    drain_results();
  endtask

  // Largest steps: a step that would overshoot the full period turns the sweep back
  // without moving, and a timer fault then parks it.
  task automatic test_step_extremes();
    write_reg(REG_SLOW_STEP, 40'd255);
    write_reg(REG_FAST_STEP, 40'd255);
    repeat (8) send_tick(tick_of(8'd255, MODE_AUTO, 12'd4095, 1'b0));
    send_tick(tick_of(8'd255, MODE_AUTO, 12'd4095, 1'b1));
    send_tick(tick_of(8'd0, MODE_WASH, 12'd4095, 1'b0));
    send_tick(tick_of(8'd128, MODE_INT_FAST, 12'd0, 1'b0));
    send_tick(tick_of(8'd0, MODE_OFF, 12'd2048, 1'b1));
    drain_results();
  endtask

  task automatic test_auto_rain();
    write_reg(REG_SLOW_STEP, 40'($urandom_range(20, 120)));
    write_reg(REG_FAST_STEP, 40'($urandom_range(100, 255)));
    write_reg(REG_RAIN_THRESHOLD, 40'($urandom_range(0, 4095)));
    send_runs(15, MODE_AUTO, 2);
    drain_results();
    write_reg(REG_RAIN_THRESHOLD, 40'd4095);
    send_runs(15, MODE_AUTO, 2);
    drain_results();
  endtask

  // A long run in fast intermittent mode at top speed lasts past the shortest
  // delay, so the interval actually fires; mixed runs follow.
  task automatic test_intermittent();
    write_reg(REG_SLOW_STEP, 40'd150);
    write_reg(REG_FAST_STEP, 40'd255);
    write_reg(REG_SPEED_LIMITS, DEFAULT_SPEED_LIMITS);
    write_reg(REG_WASH_WINDOW, 40'd0);
    write_reg(REG_WASH_WIPES, 40'd0);
    send_run(MODE_INT_FAST, 240, 51, 255, 0);
    send_runs(20, MODE_INT_SLOW, 3);
    drain_results();
  endtask

  task automatic test_wash();
    write_reg(REG_WASH_WIPES, 40'd3);
    send_run(MODE_WASH, 4, 0, 255, 0);
    send_run(MODE_OFF, 30, 0, 255, 0);
    drain_results();
    write_reg(REG_WASH_WINDOW, 40'd255);
    write_reg(REG_WASH_WIPES, 40'd1);
    send_run(MODE_WASH, 3, 0, 255, 0);
    send_run(MODE_OFF, 20, 0, 255, 0);
    drain_results();
    write_reg(REG_WASH_WINDOW, 40'($urandom_range(1, 40)));
    write_reg(REG_WASH_WIPES, 40'($urandom_range(1, 5)));
    write_reg(REG_SLOW_STEP, 40'($urandom_range(100, 255)));
    send_runs(20, MODE_WASH, 3);
    drain_results();
  endtask

  // Band limits at zero, all ones, random unordered and random ascending. Auto
  // mode with a zero threshold keeps the wiper busy so the step in use shows.
  task automatic test_speed_bands();
    logic [39:0] limits;
    int acc;
    write_reg(REG_SLOW_STEP, 40'd10);
    write_reg(REG_FAST_STEP, 40'd200);
    write_reg(REG_RAIN_THRESHOLD, 40'd0);
    for (int s = 0; s < 4; s++) begin
      case (s)
        0: limits = 40'h0;
        1: limits = 40'hFF_FFFF_FFFF;
        2: limits = {8'($urandom), 32'($urandom)};
        default: begin
          acc = 0;
          for (int k = 0; k < 5; k++) begin
            acc += $urandom_range(0, 51);
            limits[8*k +: 8] = 8'(acc);
          end
        end
      endcase
      write_reg(REG_SPEED_LIMITS, limits);
      for (int k = 0; k < 5; k++) begin
        send_tick(tick_of(limits[8*k +: 8], MODE_AUTO, pick_rain(), 1'b0));
        send_tick(tick_of(limits[8*k +: 8] + 8'd1, MODE_AUTO, pick_rain(), 1'b0));
      end
      send_run(MODE_AUTO, 2, 0, 255, 0);
      drain_results();
    end
  endtask

  // The sink holds off for a long stretch while the source keeps offering, so
  // the pipeline fills and in_ready must drop.
  task automatic test_backpressure();
    sender_steady = 1'b1;
    rx_hold_cycles = 60;
    send_runs(30, MODE_AUTO, 0);
    sender_steady = 1'b0;
    drain_results();
  endtask

  // Fully random ticks with the remaining register extremes, first back to back,
  // then with idling on both sides.
  task automatic test_noise();
    write_reg(REG_SLOW_STEP, 40'd0);
    write_reg(REG_FAST_STEP, 40'd255);
    write_reg(REG_WASH_WINDOW, 40'd255);
    write_reg(REG_WASH_WIPES, 40'd255);
    write_reg(REG_SPEED_LIMITS, {8'($urandom), 32'($urandom)});
    write_reg(REG_RAIN_THRESHOLD, 40'($urandom_range(0, 4095)));
    sender_steady = 1'b1;
    receiver_steady = 1'b1;
    repeat (20) send_tick(wic_in_t'(24'($urandom)));
    sender_steady = 1'b0;
    receiver_steady = 1'b0;
    repeat (20) send_tick(wic_in_t'(24'($urandom)));
    drain_results();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_step_extremes();
    test_auto_rain();
    test_intermittent();
    test_wash();
    test_speed_bands();
    test_backpressure();
    test_noise();

    if (mismatch_count == 0) begin
      $display("wiper_interval_wash_controller verification clean");
    end else begin
      $display("wiper_interval_wash_controller verification failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("wiper_interval_wash_controller verification failed");
    $finish;
  end

endmodule

// File: filelist.f
design/wic_pkg.sv
design/wic_level.sv
design/wiper_interval_wash_controller.sv
tb/tb_top.sv
